@@ rtl/mxr_pkg.sv @@
// Shared types, constants and geometry helpers of the maximal-rectangles bin packer.
package mxr_pkg;

  localparam int MAX_FREE = 64;
  localparam int MAX_USED = 64;
  localparam int COORD_W  = 16;

  localparam int FREE_AW = $clog2(MAX_FREE);
  localparam int FREE_CW = $clog2(MAX_FREE + 1);
  localparam int USED_AW = $clog2(MAX_USED);
  localparam int USED_CW = $clog2(MAX_USED + 1);

  // contact score: two border terms plus two overlaps per used entry
  localparam int SCORE_W = COORD_W + 2 + $clog2(MAX_USED + 1);
  localparam int KEY_W   = 40;
  localparam int AREA_W  = 2 * COORD_W;

  localparam int HEUR_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;

  localparam logic OP_CLEAR  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [HEUR_W-1:0] HEUR_SHORT   = 3'd0;
  localparam logic [HEUR_W-1:0] HEUR_BL      = 3'd1;
  localparam logic [HEUR_W-1:0] HEUR_CONTACT = 3'd2;
  localparam logic [HEUR_W-1:0] HEUR_LONG    = 3'd3;
  localparam logic [HEUR_W-1:0] HEUR_AREA    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_FLIP = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COORD_W:0]   coord_ext_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  function automatic coord_ext_t add_ext(input coord_t a, input coord_t b);
    return {1'b0, a} + {1'b0, b};
  endfunction

  // a lies within b
  function automatic logic box_inside(input box_t a, input box_t b);
    return (a.x >= b.x) && (a.y >= b.y) &&
           (add_ext(a.x, a.w) <= add_ext(b.x, b.w)) &&
           (add_ext(a.y, a.h) <= add_ext(b.y, b.h));
  endfunction

  // length shared by spans [a0,a1] and [b0,b1]
  function automatic coord_ext_t span_overlap(input coord_ext_t a0, input coord_ext_t a1,
                                             input coord_ext_t b0, input coord_ext_t b1);
    coord_ext_t hi;
    coord_ext_t lo;
    hi = (a1 < b1) ? a1 : b1;
    lo = (a0 > b0) ? a0 : b0;
    if ((a1 < b0) || (b1 < a0)) return '0;
    return hi - lo;
  endfunction

endpackage

@@ rtl/maxrects_bin_packer.sv @@
// Maximal-rectangles 2D bin packer: free/used lists in RAM under one sequencer.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: opcode; tdata: width, height, heur
//  out_    | out | out_tvalid/out_tready| tuser: placed, overflow; tdata: x,y,w,h,area
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// A clear word is handled in the idle state. An insert runs the sequencer over
// the free list: scan reads each entry and tests both orientations (contact
// scoring also reads every used entry), split keeps untouched entries in place
// and stages the pieces of cut ones, append copies the staged pieces back,
// prune checks pairs of live entries for containment, compaction packs the live
// ones. Scan, split, prune and compaction use the single free-list read port.
// in_tready is low while an insert runs and while a result waits on out_.
// Reset leaves an empty free list, which places nothing just like the zero
// sized bin of reset; only a clear word rebuilds the list from the bin size.
module maxrects_bin_packer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mxr_pkg::IN_DATA_W-1:0]    in_tdata,  // rect_width, rect_height, heuristic
  input  logic [0:0]                       in_tuser,  // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mxr_pkg::OUT_DATA_W-1:0]   out_tdata, // pos_x, pos_y, placed_width,
                                                      // placed_height, used_area
  output logic [1:0]                       out_tuser, // placed, free_overflow
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mxr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mxr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int FAW = mxr_pkg::FREE_AW;
  localparam int FCW = mxr_pkg::FREE_CW;
  localparam int UAW = mxr_pkg::USED_AW;
  localparam int UCW = mxr_pkg::USED_CW;
  localparam int CW  = mxr_pkg::COORD_W;
  localparam int SW  = mxr_pkg::SCORE_W;
  localparam int KW  = mxr_pkg::KEY_W;
  localparam int AW  = mxr_pkg::AREA_W;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_SC_RD   = 19'h00002,
    S_SC_EV   = 19'h00004,
    S_CT_RD   = 19'h00008,
    S_CT_EV   = 19'h00010,
    S_SC_CMP  = 19'h00020,
    S_SP_RD   = 19'h00040,
    S_SP_EV   = 19'h00080,
    S_SP_PUSH = 19'h00100,
    S_AP_RD   = 19'h00200,
    S_AP_WR   = 19'h00400,
    S_PR_I    = 19'h00800,
    S_PR_IL   = 19'h01000,
    S_PR_J    = 19'h02000,
    S_PR_C    = 19'h04000,
    S_CP_RD   = 19'h08000,
    S_CP_WR   = 19'h10000,
    S_AREA    = 19'h20000,
    S_FIN     = 19'h40000
  } state_t;

  // storage
  mxr_pkg::box_t free_mem [mxr_pkg::MAX_FREE];
  mxr_pkg::box_t tmp_mem  [mxr_pkg::MAX_FREE];
  mxr_pkg::box_t used_mem [mxr_pkg::MAX_USED];
  mxr_pkg::box_t free_q, tmp_q, used_q;

  // control
  state_t                     state_r, state_nxt;
  logic [FCW-1:0]             fc_r, fc_nxt;
  logic [UCW-1:0]             uc_r, uc_nxt;
  logic [AW-1:0]              area_r, area_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [FCW-1:0]             idx_r, idx_nxt, jdx_r, jdx_nxt, wr_r, wr_nxt;
  logic [FCW-1:0]             n_r, n_nxt, cnt_r, cnt_nxt, tc_r, tc_nxt;
  logic [UCW-1:0]             uidx_r, uidx_nxt;
  logic                       o_r, o_nxt;
  logic [1:0]                 p_r, p_nxt;
  logic                       found_r, found_nxt;
  logic [mxr_pkg::MAX_FREE-1:0] dead_r, dead_nxt;

  // configuration
  mxr_pkg::coord_t            bin_w_r, bin_h_r;
  logic                       flip_r;

  // payload
  mxr_pkg::coord_t            w_r, w_nxt, h_r, h_nxt;
  logic [mxr_pkg::HEUR_W-1:0] heur_r, heur_nxt;
  logic [AW-1:0]              wh_r, prod_r;
  logic [KW-1:0]              k1_r, k1_nxt, b1_r, b1_nxt;
  mxr_pkg::coord_t            k2_r, k2_nxt, b2_r, b2_nxt;
  logic [SW-1:0]              s_r, s_nxt;
  mxr_pkg::box_t              best_r, best_nxt, a_r, a_nxt;
  logic                       o_placed_r, o_placed_nxt, o_ovf_r, o_ovf_nxt;
  mxr_pkg::box_t              o_box_r, o_box_nxt;
  logic [AW-1:0]              o_area_r, o_area_nxt;

  // memory ports
  logic                       fw_en, tw_en, uw_en, fr_en, tr_en, ur_en;
  logic [FAW-1:0]             fw_addr, fr_addr, tw_addr, tr_addr;
  logic [UAW-1:0]             uw_addr, ur_addr;
  mxr_pkg::box_t              fw_data, tw_data;

  // shared multiplier
  mxr_pkg::coord_t            mul_a, mul_b;
  logic [AW-1:0]              mul_p;
  logic                       wh_ld, prod_ld;

  // datapath helpers
  mxr_pkg::coord_t            pw, ph, dh, dv, sh, lg;
  mxr_pkg::coord_ext_t        xe, ye, uxe, uye, fxe, fye, nxe, nye, c1, c2;
  logic                       elig, isect, p_cond, pushed, win, in_fire;
  mxr_pkg::box_t              p_box, node;
  logic [KW-1:0]              key1;
  logic [SW-1:0]              border;
  logic [FCW-1:0]             cnt_tmp;
  logic [AW:0]                area_sum;
  logic [mxr_pkg::HEUR_W-1:0] in_heur;
  mxr_pkg::coord_t            in_w, in_h;

  assign in_w    = in_tdata[CW-1:0];
  assign in_h    = in_tdata[2*CW-1:CW];
  assign in_heur = in_tdata[2*CW+mxr_pkg::HEUR_W-1:2*CW];

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {o_area_r, o_box_r.h, o_box_r.w, o_box_r.y, o_box_r.x};
  assign out_tuser  = {o_ovf_r, o_placed_r};

  assign mul_p = mul_a * mul_b;
  assign node  = best_r;

  // orientation under test and its geometry against the free entry in free_q
  always_comb begin
    pw   = o_r ? h_r : w_r;
    ph   = o_r ? w_r : h_r;
    elig = (!o_r || flip_r) && (free_q.w >= pw) && (free_q.h >= ph);
    dh   = free_q.w - pw;
    dv   = free_q.h - ph;
    sh   = (dh < dv) ? dh : dv;
    lg   = (dh < dv) ? dv : dh;
    xe   = mxr_pkg::add_ext(free_q.x, pw);
    ye   = mxr_pkg::add_ext(free_q.y, ph);
    uxe  = mxr_pkg::add_ext(used_q.x, used_q.w);
    uye  = mxr_pkg::add_ext(used_q.y, used_q.h);
    c1   = '0;
    c2   = '0;
    if (({1'b0, used_q.x} == xe) || (uxe == {1'b0, free_q.x}))
      c1 = mxr_pkg::span_overlap({1'b0, used_q.y}, uye, {1'b0, free_q.y}, ye);
    if (({1'b0, used_q.y} == ye) || (uye == {1'b0, free_q.y}))
      c2 = mxr_pkg::span_overlap({1'b0, used_q.x}, uxe, {1'b0, free_q.x}, xe);
    border = '0;
    if ((free_q.x == '0) || (xe == {1'b0, bin_w_r})) border = border + SW'(ph);
    if ((free_q.y == '0) || (ye == {1'b0, bin_h_r})) border = border + SW'(pw);
  end

  // split of the free entry in free_q by the placed node
  always_comb begin
    fxe   = mxr_pkg::add_ext(free_q.x, free_q.w);
    fye   = mxr_pkg::add_ext(free_q.y, free_q.h);
    nxe   = mxr_pkg::add_ext(node.x, node.w);
    nye   = mxr_pkg::add_ext(node.y, node.h);
    isect = !(({1'b0, node.x} >= fxe) || (nxe <= {1'b0, free_q.x}) ||
              ({1'b0, node.y} >= fye) || (nye <= {1'b0, free_q.y}));
    p_box = free_q;
    case (p_r)
      2'd0: begin
        p_cond  = (node.y > free_q.y) && ({1'b0, node.y} < fye);
        p_box.h = node.y - free_q.y;
      end
      2'd1: begin
        p_cond  = nye < fye;
        p_box.y = nye[CW-1:0];
        p_box.h = CW'(fye - nye);
      end
      2'd2: begin
        p_cond  = (node.x > free_q.x) && ({1'b0, node.x} < fxe);
        p_box.w = node.x - free_q.x;
      end
      default: begin
        p_cond  = nxe < fxe;
        p_box.x = nxe[CW-1:0];
        p_box.w = CW'(fxe - nxe);
      end
    endcase
  end

  // candidate key
  always_comb begin
    case (heur_r)
      mxr_pkg::HEUR_CONTACT: key1 = {KW{1'b1}} - KW'(s_r);
      mxr_pkg::HEUR_AREA:    key1 = KW'(prod_r - wh_r);
      default:               key1 = k1_r;
    endcase
    win = !found_r || (key1 < b1_r) || ((key1 == b1_r) && (k2_r < b2_r));
  end

  assign area_sum = {1'b0, area_r} + {1'b0, prod_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fc_nxt        = fc_r;
    uc_nxt        = uc_r;
    area_nxt      = area_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    jdx_nxt       = jdx_r;
    wr_nxt        = wr_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    tc_nxt        = tc_r;
    uidx_nxt      = uidx_r;
    o_nxt         = o_r;
    p_nxt         = p_r;
    found_nxt     = found_r;
    dead_nxt      = dead_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    heur_nxt      = heur_r;
    k1_nxt        = k1_r;
    k2_nxt        = k2_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    s_nxt         = s_r;
    best_nxt      = best_r;
    a_nxt         = a_r;
    o_placed_nxt  = o_placed_r;
    o_ovf_nxt     = o_ovf_r;
    o_box_nxt     = o_box_r;
    o_area_nxt    = o_area_r;
    fw_en = 1'b0;  fw_addr = wr_r[FAW-1:0];  fw_data = free_q;
    tw_en = 1'b0;  tw_addr = tc_r[FAW-1:0];  tw_data = p_box;
    uw_en = 1'b0;  uw_addr = uc_r[UAW-1:0];
    fr_en = 1'b0;  fr_addr = idx_r[FAW-1:0];
    tr_en = 1'b0;  tr_addr = idx_r[FAW-1:0];
    ur_en = 1'b0;  ur_addr = uidx_r[UAW-1:0];
    mul_a = in_w;  mul_b = in_h;
    wh_ld = 1'b0;  prod_ld = 1'b0;
    pushed  = 1'b0;
    cnt_tmp = cnt_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          w_nxt    = in_w;
          h_nxt    = in_h;
          heur_nxt = in_heur;
          if (in_tuser[0] == mxr_pkg::OP_CLEAR) begin
            fw_en        = 1'b1;
            fw_addr      = '0;
            fw_data      = '{x: '0, y: '0, w: bin_w_r, h: bin_h_r};
            fc_nxt       = FCW'(1);
            uc_nxt       = '0;
            area_nxt     = '0;
            ovf_nxt      = 1'b0;
            o_placed_nxt = 1'b0;
            o_box_nxt    = '0;
            o_ovf_nxt    = 1'b0;
            o_area_nxt   = '0;
            out_valid_nxt = 1'b1;
          end else if ((in_w == '0) || (in_h == '0) || (in_heur > mxr_pkg::HEUR_AREA)) begin
            o_placed_nxt  = 1'b0;
            o_box_nxt     = '0;
            o_ovf_nxt     = ovf_r;
            o_area_nxt    = area_r;
            out_valid_nxt = 1'b1;
          end else begin
            wh_ld     = 1'b1;
            idx_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_SC_RD;
          end
        end
      end
      // ---- search ----
      S_SC_RD: begin
        if (idx_r == fc_r) begin
          if (found_r) begin
            idx_nxt   = '0;
            wr_nxt    = '0;
            n_nxt     = fc_r;
            cnt_nxt   = fc_r;
            tc_nxt    = '0;
            state_nxt = S_SP_RD;
          end else begin
            o_placed_nxt  = 1'b0;
            o_box_nxt     = '0;
            o_ovf_nxt     = ovf_r;
            o_area_nxt    = area_r;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          fr_en     = 1'b1;
          o_nxt     = 1'b0;
          state_nxt = S_SC_EV;
        end
      end
      S_SC_EV: begin
        mul_a = free_q.w;
        mul_b = free_q.h;
        if (!elig) begin
          if (!o_r) begin
            o_nxt = 1'b1;
          end else begin
            idx_nxt   = idx_r + FCW'(1);
            state_nxt = S_SC_RD;
          end
        end else begin
          prod_ld = 1'b1;
          case (heur_r)
            mxr_pkg::HEUR_SHORT: begin
              k1_nxt = KW'(sh);
              k2_nxt = lg;
            end
            mxr_pkg::HEUR_BL: begin
              k1_nxt = KW'(ye);
              k2_nxt = free_q.x;
            end
            mxr_pkg::HEUR_LONG: begin
              k1_nxt = KW'(lg);
              k2_nxt = sh;
            end
            mxr_pkg::HEUR_CONTACT: begin
              k2_nxt = '0;
            end
            default: begin
              k2_nxt = sh;
            end
          endcase
          if (heur_r == mxr_pkg::HEUR_CONTACT) begin
            s_nxt     = border;
            uidx_nxt  = '0;
            state_nxt = S_CT_RD;
          end else begin
            state_nxt = S_SC_CMP;
          end
        end
      end
      S_CT_RD: begin
        if (uidx_r == uc_r) begin
          state_nxt = S_SC_CMP;
        end else begin
          ur_en     = 1'b1;
          state_nxt = S_CT_EV;
        end
      end
      S_CT_EV: begin
        s_nxt     = s_r + SW'(c1) + SW'(c2);
        uidx_nxt  = uidx_r + UCW'(1);
        state_nxt = S_CT_RD;
      end
      S_SC_CMP: begin
        if (win) begin
          found_nxt = 1'b1;
          b1_nxt    = key1;
          b2_nxt    = k2_r;
          best_nxt  = '{x: free_q.x, y: free_q.y, w: pw, h: ph};
        end
        if (!o_r) begin
          o_nxt     = 1'b1;
          state_nxt = S_SC_EV;
        end else begin
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_SC_RD;
        end
      end
      // ---- split: survivors packed in place, new pieces staged aside ----
      S_SP_RD: begin
        if (idx_r == n_r) begin
          idx_nxt   = '0;
          state_nxt = S_AP_RD;
        end else begin
          fr_en     = 1'b1;
          state_nxt = S_SP_EV;
        end
      end
      S_SP_EV: begin
        if (!isect) begin
          fw_en     = 1'b1;
          wr_nxt    = wr_r + FCW'(1);
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_SP_RD;
        end else begin
          p_nxt     = '0;
          state_nxt = S_SP_PUSH;
        end
      end
      S_SP_PUSH: begin
        if (p_cond) begin
          if (cnt_r < FCW'(mxr_pkg::MAX_FREE)) begin
            tw_en  = 1'b1;
            tc_nxt = tc_r + FCW'(1);
            pushed = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        cnt_tmp = pushed ? (cnt_r + FCW'(1)) : cnt_r;
        cnt_nxt = cnt_tmp;
        if (p_r == 2'd3) begin
          cnt_nxt   = cnt_tmp - FCW'(1);
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_SP_RD;
        end else begin
          p_nxt = p_r + 2'd1;
        end
      end
      S_AP_RD: begin
        if (idx_r == tc_r) begin
          fc_nxt    = wr_r;
          idx_nxt   = '0;
          dead_nxt  = '0;
          state_nxt = S_PR_I;
        end else begin
          tr_en     = 1'b1;
          state_nxt = S_AP_WR;
        end
      end
      S_AP_WR: begin
        fw_en     = 1'b1;
        fw_data   = tmp_q;
        wr_nxt    = wr_r + FCW'(1);
        idx_nxt   = idx_r + FCW'(1);
        state_nxt = S_AP_RD;
      end
      // ---- prune: mark contained entries dead ----
      S_PR_I: begin
        if (idx_r == fc_r) begin
          idx_nxt   = '0;
          wr_nxt    = '0;
          state_nxt = S_CP_RD;
        end else if (dead_r[idx_r[FAW-1:0]]) begin
          idx_nxt = idx_r + FCW'(1);
        end else begin
          fr_en     = 1'b1;
          state_nxt = S_PR_IL;
        end
      end
      S_PR_IL: begin
        a_nxt     = free_q;
        jdx_nxt   = idx_r + FCW'(1);
        state_nxt = S_PR_J;
      end
      S_PR_J: begin
        if (jdx_r == fc_r) begin
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_PR_I;
        end else if (dead_r[jdx_r[FAW-1:0]]) begin
          jdx_nxt = jdx_r + FCW'(1);
        end else begin
          fr_en     = 1'b1;
          fr_addr   = jdx_r[FAW-1:0];
          state_nxt = S_PR_C;
        end
      end
      S_PR_C: begin
        if (mxr_pkg::box_inside(a_r, free_q)) begin
          dead_nxt[idx_r[FAW-1:0]] = 1'b1;
          idx_nxt   = idx_r + FCW'(1);
          state_nxt = S_PR_I;
        end else begin
          if (mxr_pkg::box_inside(free_q, a_r)) dead_nxt[jdx_r[FAW-1:0]] = 1'b1;
          jdx_nxt   = jdx_r + FCW'(1);
          state_nxt = S_PR_J;
        end
      end
      // ---- compaction of live entries ----
      S_CP_RD: begin
        if (idx_r == fc_r) begin
          fc_nxt    = wr_r;
          state_nxt = S_AREA;
        end else if (dead_r[idx_r[FAW-1:0]]) begin
          idx_nxt = idx_r + FCW'(1);
        end else begin
          fr_en     = 1'b1;
          state_nxt = S_CP_WR;
        end
      end
      S_CP_WR: begin
        fw_en     = 1'b1;
        wr_nxt    = wr_r + FCW'(1);
        idx_nxt   = idx_r + FCW'(1);
        state_nxt = S_CP_RD;
      end
      S_AREA: begin
        mul_a     = node.w;
        mul_b     = node.h;
        prod_ld   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (uc_r < UCW'(mxr_pkg::MAX_USED)) begin
          uw_en  = 1'b1;
          uc_nxt = uc_r + UCW'(1);
        end
        area_nxt      = area_sum[AW] ? {AW{1'b1}} : area_sum[AW-1:0];
        o_placed_nxt  = 1'b1;
        o_box_nxt     = node;
        o_ovf_nxt     = ovf_r;
        o_area_nxt    = area_sum[AW] ? {AW{1'b1}} : area_sum[AW-1:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (fw_en) free_mem[fw_addr] <= fw_data;
    if (fr_en) free_q <= free_mem[fr_addr];
  end

  always_ff @(posedge clk) begin
    if (tw_en) tmp_mem[tw_addr] <= tw_data;
    if (tr_en) tmp_q <= tmp_mem[tr_addr];
  end

  always_ff @(posedge clk) begin
    if (uw_en) used_mem[uw_addr] <= node;
    if (ur_en) used_q <= used_mem[ur_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= '0;
      uc_r        <= '0;
      area_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      jdx_r       <= '0;
      wr_r        <= '0;
      n_r         <= '0;
      cnt_r       <= '0;
      tc_r        <= '0;
      uidx_r      <= '0;
      o_r         <= 1'b0;
      p_r         <= '0;
      found_r     <= 1'b0;
      bin_w_r     <= '0;
      bin_h_r     <= '0;
      flip_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      uc_r        <= uc_nxt;
      area_r      <= area_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      jdx_r       <= jdx_nxt;
      wr_r        <= wr_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      tc_r        <= tc_nxt;
      uidx_r      <= uidx_nxt;
      o_r         <= o_nxt;
      p_r         <= p_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mxr_pkg::CFG_BIN_WIDTH:  bin_w_r <= cfg_data[CW-1:0];
          mxr_pkg::CFG_BIN_HEIGHT: bin_h_r <= cfg_data[CW-1:0];
          mxr_pkg::CFG_ALLOW_FLIP: flip_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dead_r     <= dead_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    heur_r     <= heur_nxt;
    k1_r       <= k1_nxt;
    k2_r       <= k2_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    s_r        <= s_nxt;
    best_r     <= best_nxt;
    a_r        <= a_nxt;
    o_placed_r <= o_placed_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_box_r    <= o_box_nxt;
    o_area_r   <= o_area_nxt;
    if (wh_ld)   wh_r   <= mul_p;
    if (prod_ld) prod_r <= mul_p;
  end

  // checks
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FCW'(mxr_pkg::MAX_FREE))
    else $error("free count beyond capacity");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uc_r <= UCW'(mxr_pkg::MAX_USED))
    else $error("used count beyond capacity");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_tvalid)
    else $error("result shown while sequencer busy");

  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SP_PUSH) |-> (cnt_r >= tc_r))
    else $error("staged pieces exceed tracked count");

endmodule
